// ----- hw/rtl/jsu_pkg.sv -----
package jsu_pkg;

  // result kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_ERR   = 2'd2;

  // error codes
  localparam logic [1:0] ERR_NO_QUOTE = 2'd0;
  localparam logic [1:0] ERR_BAD_HEX  = 2'd1;
  localparam logic [1:0] ERR_ESCAPE   = 2'd2;
  localparam logic [1:0] ERR_UNTERM   = 2'd3;

  // most results one input word can cause
  localparam int MaxRes = 3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [1:0] err;
  } res_t;

  typedef struct packed {
    logic [1:0]            cnt;
    res_t [MaxRes-1:0]     res;
  } dec_out_t;

endpackage

// ----- hw/rtl/jsu_decode.sv -----
module jsu_decode (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic [7:0]       byte_value,
  input  logic             end_mark,
  input  logic             strict_mode,
  output jsu_pkg::dec_out_t dec
);
  import jsu_pkg::*;

  typedef enum logic [1:0] {
    WAIT,
    STR,
    ESC,
    HEX
  } mode_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;

  mode_t       mode, mode_next;
  logic [11:0] hex_accum, hex_accum_next;
  logic [1:0]  hex_count, hex_count_next;

  logic        is_hex;
  logic [3:0]  hex_val;
  logic [15:0] cp;

  always_comb begin
    is_hex  = 1'b1;
    hex_val = byte_value[3:0];
    if (byte_value inside {[8'h30:8'h39]}) begin
      hex_val = byte_value[3:0];
    end else if (byte_value inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      hex_val = byte_value[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
  end

  assign cp = {hex_accum, hex_val};

  function automatic res_t mk(input logic [1:0] kind, input logic [7:0] data,
                              input logic [1:0] err);
    res_t r;
    r.kind = kind;
    r.data = data;
    r.err  = err;
    return r;
  endfunction

  always_comb begin
    dec            = '0;
    mode_next      = mode;
    hex_accum_next = hex_accum;
    hex_count_next = hex_count;
    if (end_mark) begin
      if (mode != WAIT) begin
        dec.cnt    = 2'd1;
        dec.res[0] = mk(KIND_ERR, 8'h00, ERR_UNTERM);
      end
      mode_next      = WAIT;
      hex_accum_next = '0;
      hex_count_next = '0;
    end else begin
      case (mode)
        STR: begin
          if (byte_value == CH_BSLASH) begin
            mode_next = ESC;
          end else if (byte_value == CH_QUOTE) begin
            dec.cnt    = 2'd1;
            dec.res[0] = mk(KIND_CLOSE, 8'h00, ERR_NO_QUOTE);
            mode_next  = WAIT;
          end else begin
            dec.cnt    = 2'd1;
            dec.res[0] = mk(KIND_BYTE, byte_value, ERR_NO_QUOTE);
          end
        end
        ESC: begin
          mode_next = STR;
          dec.cnt   = 2'd1;
          case (byte_value)
            CH_QUOTE, CH_BSLASH, CH_SLASH:
              dec.res[0] = mk(KIND_BYTE, byte_value, ERR_NO_QUOTE);
            CH_B: dec.res[0] = mk(KIND_BYTE, 8'h08, ERR_NO_QUOTE);
            CH_F: dec.res[0] = mk(KIND_BYTE, 8'h0C, ERR_NO_QUOTE);
            CH_N: dec.res[0] = mk(KIND_BYTE, 8'h0A, ERR_NO_QUOTE);
            CH_R: dec.res[0] = mk(KIND_BYTE, 8'h0D, ERR_NO_QUOTE);
            CH_T: dec.res[0] = mk(KIND_BYTE, 8'h09, ERR_NO_QUOTE);
            CH_U: begin
              dec.cnt        = 2'd0;
              mode_next      = HEX;
              hex_accum_next = '0;
              hex_count_next = '0;
            end
            default: begin
              if (strict_mode) begin
                dec.res[0] = mk(KIND_ERR, 8'h00, ERR_ESCAPE);
                mode_next  = WAIT;
              end else begin
                dec.res[0] = mk(KIND_BYTE, byte_value, ERR_NO_QUOTE);
              end
            end
          endcase
        end
        HEX: begin
          if (!is_hex) begin
            dec.cnt        = 2'd1;
            dec.res[0]     = mk(KIND_ERR, 8'h00, ERR_BAD_HEX);
            mode_next      = WAIT;
            hex_accum_next = '0;
            hex_count_next = '0;
          end else if (hex_count != 2'd3) begin
            hex_accum_next = {hex_accum[7:0], hex_val};
            hex_count_next = hex_count + 2'd1;
          end else begin
            // fourth digit: utf-8 encode the code point
            if (cp[15:7] == '0) begin
              dec.cnt    = 2'd1;
              dec.res[0] = mk(KIND_BYTE, cp[7:0], ERR_NO_QUOTE);
            end else if (cp[15:11] == '0) begin
              dec.cnt    = 2'd2;
              dec.res[0] = mk(KIND_BYTE, {3'b110, cp[10:6]}, ERR_NO_QUOTE);
              dec.res[1] = mk(KIND_BYTE, {2'b10, cp[5:0]}, ERR_NO_QUOTE);
            end else begin
              dec.cnt    = 2'd3;
              dec.res[0] = mk(KIND_BYTE, {4'b1110, cp[15:12]}, ERR_NO_QUOTE);
              dec.res[1] = mk(KIND_BYTE, {2'b10, cp[11:6]}, ERR_NO_QUOTE);
              dec.res[2] = mk(KIND_BYTE, {2'b10, cp[5:0]}, ERR_NO_QUOTE);
            end
            mode_next      = STR;
            hex_accum_next = '0;
            hex_count_next = '0;
          end
        end
        default: begin
          if (byte_value == CH_QUOTE) begin
            mode_next      = STR;
            hex_accum_next = '0;
            hex_count_next = '0;
          end else begin
            dec.cnt    = 2'd1;
            dec.res[0] = mk(KIND_ERR, 8'h00, ERR_NO_QUOTE);
            mode_next  = WAIT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= WAIT;
      hex_accum <= '0;
      hex_count <= '0;
    end else if (adv) begin
      mode      <= mode_next;
      hex_accum <= hex_accum_next;
      hex_count <= hex_count_next;
    end
  end

endmodule

// ----- hw/rtl/jsu_out_queue.sv -----
module jsu_out_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  jsu_pkg::dec_out_t dec,
  output logic              can_load,
  output logic              m_tvalid,
  input  logic              m_tready,
  output jsu_pkg::res_t     head,
  output logic              head_last
);
  import jsu_pkg::*;

  res_t [MaxRes-1:0] q;
  logic [1:0]        cnt;
  logic              pop;

  assign m_tvalid  = (cnt != 2'd0);
  assign pop       = m_tvalid && m_tready;
  // refill once the last pending word leaves
  assign can_load  = (cnt == 2'd0) || ((cnt == 2'd1) && m_tready);
  assign head      = q[0];
  assign head_last = (cnt == 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= dec.cnt;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q <= dec.res;
    end else if (pop) begin
      q[0] <= q[1];
      q[1] <= q[2];
    end
  end

endmodule

// ----- hw/rtl/json_string_unescape.sv -----
// json string unescaper
// s_* channel: one raw byte per word. s_tdata carries the byte; s_tuser set
// means the input has ended and the byte is ignored.
// m_* channel: one decoded result per word. m_tuser is the result kind
// (decoded byte, string closed, error), m_tdata holds the byte and the error
// code, m_tlast flags the last result caused by one input word.
// cfg_* channel: writes the strict flag; always ready, write only while idle.
// path: an accepted word lands in the input register, is decoded and is
// loaded into the result queue once the queue can take it; its first result
// then shows on m_*.
// throughput: one input word per cycle while m_tready is high and each word
// gives at most one result; a \u escape that gives two or three utf-8 bytes
// holds the input while the result queue drains, one result per cycle.
// stall: with m_tready low the result queue holds, then the input register
// fills and s_tready drops; nothing is lost or repeated.
// reset: clears the queue and the input register, waits for an opening
// quote and clears the strict flag.
module json_string_unescape (
  input  logic        clk,
  input  logic        rst,
  // input word: [7:0] byte_value
  input  logic [7:0]  s_tdata,
  // input flag: [0] end_mark
  input  logic        s_tuser,
  input  logic        s_tvalid,
  output logic        s_tready,
  // result word: [7:0] out_byte, [9:8] error_code, [15:10] zero
  output logic [15:0] m_tdata,
  // result flag: [1:0] result_kind
  output logic [1:0]  m_tuser,
  output logic        m_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);
  import jsu_pkg::*;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_end;

  logic       strict_mode;
  logic       can_load;
  logic       adv;
  dec_out_t   dec;
  res_t       head;

  assign cfg_ready = 1'b1;
  assign adv       = in_valid && can_load;
  assign s_tready  = !in_valid || can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      strict_mode <= 1'b0;
      in_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        strict_mode <= cfg_data;
      end
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_end  <= s_tuser;
    end
  end

  jsu_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .byte_value  (in_byte),
    .end_mark    (in_end),
    .strict_mode (strict_mode),
    .dec         (dec)
  );

  jsu_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .load      (adv),
    .dec       (dec),
    .can_load  (can_load),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .head      (head),
    .head_last (m_tlast)
  );

  assign m_tdata = {6'd0, head.err, head.data};
  assign m_tuser = head.kind;

endmodule
